// File: rtl/cspg_pkg.sv
// Shared types and constants for the step and direction pulse generator.
package cspg_pkg;

  localparam int COUNTER_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam int PSC_BITS = 18;
  localparam int DIVISOR_BITS = 50;
  localparam int DIV_STEPS = 32;
  localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS + 1);

  localparam logic [31:0] DIRECT_LIMIT = 32'd65536;
  localparam logic [31:0] PRESCALE_DIVISOR = 32'd60000;
  localparam logic [31:0] CLOCK_HZ_RESET = 32'd72000000;

  // Division by 60000 is done as (total >> 5) / 1875 with a reciprocal that is exact
  // for every 32-bit total.
  localparam int PSC_PRE_SHIFT = 5;
  localparam int PSC_RECIP_BITS = 28;
  localparam int PSC_RECIP_SHIFT = 38;
  localparam int PSC_PROD_BITS = 32 - PSC_PRE_SHIFT + PSC_RECIP_BITS;
  localparam int PSC_QUOT_BITS = PSC_PROD_BITS - PSC_RECIP_SHIFT;
  localparam logic [PSC_RECIP_BITS-1:0] PSC_RECIP = 28'd146601551;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCK_HZ = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE_POL = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SPEED = 2'd1,
    REQ_MOVE  = 2'd2,
    REQ_STOP  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SEL_TOTAL,
    SEL_ARR
  } div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TOTAL,
    ST_DIV_PSC,
    ST_MUL,
    ST_ARR_START,
    ST_DIV_ARR
  } state_t;

  typedef struct packed {
    logic     exec;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_total;
    logic     latch_psc;
    logic     latch_mul;
    logic     apply_direct;
    logic     apply_scaled;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic req_speed;
    logic speed_ok;
    logic div_done;
    logic total_direct;
  } status_t;

endpackage

// File: rtl/cspg_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module cspg_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [31:0]                        dividend,
  input  logic [cspg_pkg::DIVISOR_BITS-1:0]  divisor,
  output logic [31:0]                        quotient,
  output logic                               done
);

  logic [31:0]                             quot;
  logic [31:0]                             rem;
  logic [cspg_pkg::DIVISOR_BITS-1:0]       dvs;
  logic [cspg_pkg::DIV_COUNT_BITS-1:0]     count;
  logic [32:0]                             trial;
  logic [32:0]                             diff;
  logic                                    ge;

  always_comb begin
    trial = {rem, quot[31]};
    ge = {{(cspg_pkg::DIVISOR_BITS - 33){1'b0}}, trial} >= dvs;
    diff = trial - dvs[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else if (start) begin
      count <= cspg_pkg::DIV_COUNT_BITS'(cspg_pkg::DIV_STEPS);
      done <= 1'b0;
    end else begin
      done <= (count == cspg_pkg::DIV_COUNT_BITS'(1));
      if (count != '0) begin
        count <= count - cspg_pkg::DIV_COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (count != '0) begin
      quot <= {quot[30:0], ge};
      rem <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign quotient = quot;

endmodule

// File: rtl/cspg_datapath.sv
// Datapath: configuration, motion state, speed calculation and result register.
module cspg_datapath #(
  parameter int COUNTER_BITS = cspg_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [cspg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cspg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [1:0]                           req_type,
  input  logic [31:0]                          step_freq_hz,
  input  logic [31:0]                          step_count,
  input  logic                                 dir_request,
  input  cspg_pkg::cmd_t                       cmd,
  output cspg_pkg::status_t                    status,
  output logic                                 step_pin,
  output logic                                 dir_pin,
  output logic                                 enable_pin,
  output logic                                 busy_res,
  output logic [31:0]                          remaining,
  output logic                                 period_end
);

  localparam int CB = COUNTER_BITS;
  localparam logic [32:0] CNT_MAX = (33'd1 << CB) - 33'd1;

  function automatic logic [CB-1:0] sat_cnt(input logic [31:0] v);
    logic [CB-1:0] r;
    if ({1'b0, v} > CNT_MAX) begin
      r = CNT_MAX[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  logic [31:0]                        clock_hz;
  logic                               enable_active_low;
  logic [31:0]                        freq;
  logic [31:0]                        total;
  logic [cspg_pkg::PSC_BITS-1:0]      psc;
  logic [cspg_pkg::DIVISOR_BITS-1:0]  product;
  logic [cspg_pkg::PSC_PROD_BITS-1:0] psc_prod;
  logic [cspg_pkg::PSC_QUOT_BITS-1:0] psc_quot;

  logic [31:0]   steps_to_go, steps_to_go_next;
  logic          moving, moving_next;
  logic [CB-1:0] prescale_active, prescale_active_next;
  logic [CB-1:0] period_active, period_active_next;
  logic [CB-1:0] prescale_pending, prescale_pending_next;
  logic [CB-1:0] period_pending, period_pending_next;
  logic [CB-1:0] prescale_count, prescale_count_next;
  logic [CB-1:0] period_count, period_count_next;
  logic          direction_level, direction_level_next;
  logic          energized, energized_next;
  logic          pend;

  logic [31:0]                        div_dividend;
  logic [cspg_pkg::DIVISOR_BITS-1:0]  div_divisor;
  logic [31:0]                        div_q;
  logic                               div_done;
  logic [CB-1:0]                      psc_new;
  logic [CB-1:0]                      arr_new;

  cspg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    unique case (cmd.div_sel)
      cspg_pkg::SEL_TOTAL: begin
        div_dividend = clock_hz;
        div_divisor = cspg_pkg::DIVISOR_BITS'(step_freq_hz);
      end
      default: begin
        div_dividend = clock_hz;
        div_divisor = product;
      end
    endcase
  end

  always_comb begin
    psc_prod = cspg_pkg::PSC_PROD_BITS'(total[31:cspg_pkg::PSC_PRE_SHIFT])
             * cspg_pkg::PSC_PROD_BITS'(cspg_pkg::PSC_RECIP);
    psc_quot = psc_prod[cspg_pkg::PSC_PROD_BITS-1:cspg_pkg::PSC_RECIP_SHIFT];
  end

  always_comb begin
    status.req_speed = (cspg_pkg::req_t'(req_type) == cspg_pkg::REQ_SPEED);
    status.speed_ok = (step_freq_hz != 32'd0) && (step_freq_hz <= clock_hz);
    status.div_done = div_done;
    status.total_direct = (div_q <= cspg_pkg::DIRECT_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= cspg_pkg::CLOCK_HZ_RESET;
      enable_active_low <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cspg_pkg::CFG_CLOCK_HZ: clock_hz <= cfg_data;
        cspg_pkg::CFG_ENABLE_POL: enable_active_low <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == cspg_pkg::SEL_TOTAL) begin
      freq <= step_freq_hz;
    end
    if (cmd.latch_total) begin
      total <= div_q;
    end
    if (cmd.latch_psc) begin
      if ({{(33 - cspg_pkg::PSC_QUOT_BITS){1'b0}}, psc_quot} > CNT_MAX) begin
        psc <= CNT_MAX[cspg_pkg::PSC_BITS-1:0];
      end else begin
        psc <= cspg_pkg::PSC_BITS'(psc_quot);
      end
    end
    if (cmd.latch_mul) begin
      product <= (cspg_pkg::DIVISOR_BITS'(psc) + cspg_pkg::DIVISOR_BITS'(1))
               * cspg_pkg::DIVISOR_BITS'(freq);
    end
  end

  always_comb begin
    steps_to_go_next = steps_to_go;
    moving_next = moving;
    prescale_active_next = prescale_active;
    period_active_next = period_active;
    prescale_pending_next = prescale_pending;
    period_pending_next = period_pending;
    prescale_count_next = prescale_count;
    period_count_next = period_count;
    direction_level_next = direction_level;
    energized_next = energized;
    pend = 1'b0;
    psc_new = '0;
    arr_new = '0;

    if (cmd.apply_direct) begin
      psc_new = '0;
      arr_new = sat_cnt(div_q - 32'd1);
    end else begin
      psc_new = CB'(psc);
      arr_new = (div_q == 32'd0) ? '0 : sat_cnt(div_q - 32'd1);
    end

    if (cmd.apply_direct || cmd.apply_scaled) begin
      prescale_pending_next = psc_new;
      period_pending_next = arr_new;
      if (!moving) begin
        prescale_active_next = psc_new;
        period_active_next = arr_new;
        prescale_count_next = '0;
        period_count_next = '0;
      end
    end

    if (cmd.exec) begin
      unique case (cspg_pkg::req_t'(req_type))
        cspg_pkg::REQ_TICK: begin
          if (moving && period_active != '0) begin
            if (prescale_count < prescale_active) begin
              prescale_count_next = prescale_count + CB'(1);
            end else begin
              prescale_count_next = '0;
              if (period_count < period_active) begin
                period_count_next = period_count + CB'(1);
              end else begin
                period_count_next = '0;
                prescale_active_next = prescale_pending;
                period_active_next = period_pending;
                if (steps_to_go != 32'd0) begin
                  steps_to_go_next = steps_to_go - 32'd1;
                end
                if (steps_to_go_next == 32'd0) begin
                  moving_next = 1'b0;
                end
                pend = 1'b1;
              end
            end
          end
        end
        cspg_pkg::REQ_SPEED: ;
        cspg_pkg::REQ_MOVE: begin
          if (step_count != 32'd0 && !moving) begin
            steps_to_go_next = step_count;
            moving_next = 1'b1;
            direction_level_next = dir_request;
            energized_next = 1'b1;
            prescale_count_next = '0;
            period_count_next = '0;
          end
        end
        cspg_pkg::REQ_STOP: begin
          moving_next = 1'b0;
          steps_to_go_next = 32'd0;
          energized_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_to_go <= '0;
      moving <= 1'b0;
      prescale_active <= '0;
      period_active <= '0;
      prescale_pending <= '0;
      period_pending <= '0;
      prescale_count <= '0;
      period_count <= '0;
      direction_level <= 1'b0;
      energized <= 1'b0;
    end else begin
      steps_to_go <= steps_to_go_next;
      moving <= moving_next;
      prescale_active <= prescale_active_next;
      period_active <= period_active_next;
      prescale_pending <= prescale_pending_next;
      period_pending <= period_pending_next;
      prescale_count <= prescale_count_next;
      period_count <= period_count_next;
      direction_level <= direction_level_next;
      energized <= energized_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      step_pin <= moving_next && (period_count_next < (period_active_next >> 1));
      dir_pin <= direction_level_next;
      enable_pin <= energized_next ^ enable_active_low;
      busy_res <= moving_next;
      remaining <= steps_to_go_next;
      period_end <= pend;
    end
  end

endmodule

// File: rtl/cspg_ctrl.sv
// Controller state machine that sequences requests and the speed calculation.
module cspg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cspg_pkg::status_t  status,
  output cspg_pkg::cmd_t     cmd
);

  cspg_pkg::state_t state, state_next;
  logic             out_free;
  logic             accept;

  assign out_free = !(out_valid && out_stall);
  assign accept = in_valid && (state == cspg_pkg::ST_IDLE) && out_free;
  assign in_stall = !((state == cspg_pkg::ST_IDLE) && out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      cspg_pkg::ST_IDLE: begin
        if (accept && status.req_speed && status.speed_ok) begin
          state_next = cspg_pkg::ST_DIV_TOTAL;
        end
      end
      cspg_pkg::ST_DIV_TOTAL: begin
        if (status.div_done) begin
          state_next = status.total_direct ? cspg_pkg::ST_IDLE : cspg_pkg::ST_DIV_PSC;
        end
      end
      cspg_pkg::ST_DIV_PSC: state_next = cspg_pkg::ST_MUL;
      cspg_pkg::ST_MUL: state_next = cspg_pkg::ST_ARR_START;
      cspg_pkg::ST_ARR_START: state_next = cspg_pkg::ST_DIV_ARR;
      cspg_pkg::ST_DIV_ARR: begin
        if (status.div_done) begin
          state_next = cspg_pkg::ST_IDLE;
        end
      end
      default: state_next = cspg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = cspg_pkg::SEL_TOTAL;
    unique case (state)
      cspg_pkg::ST_IDLE: begin
        if (accept) begin
          if (status.req_speed && status.speed_ok) begin
            cmd.div_start = 1'b1;
          end else begin
            cmd.exec = 1'b1;
            cmd.load_out = 1'b1;
          end
        end
      end
      cspg_pkg::ST_DIV_TOTAL: begin
        if (status.div_done) begin
          if (status.total_direct) begin
            cmd.apply_direct = 1'b1;
            cmd.load_out = 1'b1;
          end else begin
            cmd.latch_total = 1'b1;
          end
        end
      end
      cspg_pkg::ST_DIV_PSC: begin
        cmd.latch_psc = 1'b1;
      end
      cspg_pkg::ST_MUL: begin
        cmd.latch_mul = 1'b1;
      end
      cspg_pkg::ST_ARR_START: begin
        cmd.div_sel = cspg_pkg::SEL_ARR;
        cmd.div_start = 1'b1;
      end
      cspg_pkg::ST_DIV_ARR: begin
        cmd.div_sel = cspg_pkg::SEL_ARR;
        if (status.div_done) begin
          cmd.apply_scaled = 1'b1;
          cmd.load_out = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cspg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= cmd.load_out || (out_valid && out_stall);
    end
  end

endmodule

// File: rtl/counted_step_pulse_generator.sv
// Top level of the counted step and direction pulse generator.
// Every accepted word gives one result word that shows the state after the request.
// Ticks, moves, stops and ignored set-speed requests can follow each other in every
// cycle while the result output does not stall. A set-speed request with a usable
// frequency runs through a shared divider that yields one quotient bit per cycle; no
// new word is accepted until the division ends when the clock divider fits the counter
// directly, or until a prescaler has been worked out and a second division has ended.
module counted_step_pulse_generator #(
  parameter int COUNTER_BITS = cspg_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [cspg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cspg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           req_type,
  input  logic [31:0]                          step_freq_hz,
  input  logic [31:0]                          step_count,
  input  logic                                 dir_request,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 step_pin,
  output logic                                 dir_pin,
  output logic                                 enable_pin,
  output logic                                 busy_res,
  output logic [31:0]                          remaining,
  output logic                                 period_end
);

  cspg_pkg::cmd_t    cmd;
  cspg_pkg::status_t status;

  cspg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cspg_datapath #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .step_freq_hz (step_freq_hz),
    .step_count   (step_count),
    .dir_request  (dir_request),
    .cmd          (cmd),
    .status       (status),
    .step_pin     (step_pin),
    .dir_pin      (dir_pin),
    .enable_pin   (enable_pin),
    .busy_res     (busy_res),
    .remaining    (remaining),
    .period_end   (period_end)
  );

endmodule
